// ----- hw/rtl/tbdr_pkg.sv -----
// Shared types and constants for the trackball drag rotation block.
// Used by the controller, the datapath and the iterative arithmetic units.
`timescale 1ns / 1ps

package tbdr_pkg;

  // Quaternion one in Q1.14
  localparam int unsigned OneQ14 = 16384;

  // Widths of the shared square root and divider units
  localparam int unsigned RootW = 32;
  localparam int unsigned SqOpW = 2 * RootW;
  localparam int unsigned DvdW  = 48;
  localparam int unsigned DvsW  = 33;

  // Datapath steps issued by the controller
  typedef enum logic [5:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SQ_X,
    CMD_SQ_Y,
    CMD_SQRT_IN,
    CMD_SQRT_D2,
    CMD_DIV_Z,
    CMD_Z_SQRT,
    CMD_Z_DIV,
    CMD_A0A,
    CMD_A0B,
    CMD_A1A,
    CMD_A1B,
    CMD_A2A,
    CMD_A2B,
    CMD_ABS,
    CMD_NORM,
    CMD_MM0,
    CMD_MM1,
    CMD_MM2,
    CMD_SQRT_N,
    CMD_N_WR,
    CMD_DD0,
    CMD_DD1,
    CMD_DD2,
    CMD_TBIG,
    CMD_SQRT_T,
    CMD_T_WR,
    CMD_SQRT_W,
    CMD_W_WR,
    CMD_QM,
    CMD_DIV_Q,
    CMD_Q_WR,
    CMD_PRD,
    CMD_SHF,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } tbdr_cmd_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic zero_off;
    logic pt_second;
    logic in_sphere;
    logic zero_axis;
    logic norm_ok;
    logic big;
    logic sqrt_busy;
    logic div_busy;
    logic q_last;
    logic p_last;
    logic s_last;
  } tbdr_status_t;

endpackage

// ----- hw/rtl/trackball_drag_rotation.sv -----
// Trackball drag rotation, top level.
// Depends on tbdr_pkg, tbdr_ctrl and tbdr_datapath.
//
// Usage:
//   Slave channel: one word per drag update (grab point, offset, and an
//   optional new rotation center flagged in tuser). Master channel: one word
//   per update with the Q1.14 rotation quaternion and the Q16.16 translation
//   c - R*c, saturated.
//   One update is processed at a time. A zero offset goes straight to the
//   product and shift steps, a zero axis goes there after the lift and axis
//   steps, and the time of a full update is set by the bit-serial square
//   root (up to five roots), the restoring divider (up to five quotients)
//   that the datapath shares, and up to 29 axis normalization shifts.
//   The result sits in an output register, so the next word is accepted as
//   soon as the previous one has been moved there; a stalled receiver only
//   holds the block once a second result is ready to move.
//   Reset clears the stored center to zero, the controller to idle and the
//   output valid flag.
`timescale 1ns / 1ps

module trackball_drag_rotation (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // grab_x, grab_y, offset_x, offset_y, center_x, center_y, center_z
  input  logic [159:0] s_axis_tdata_i,
  // center_valid
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // quat_x, quat_y, quat_z, quat_w, shift_x, shift_y, shift_z
  output logic [159:0] m_axis_tdata_o
);
  import tbdr_pkg::*;

  tbdr_cmd_t    cmd;
  tbdr_status_t status;
  logic [15:0]  quat_x, quat_y, quat_z, quat_w;
  logic [31:0]  shift_x, shift_y, shift_z;

  tbdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tbdr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .grab_x_i       (s_axis_tdata_i[15:0]),
    .grab_y_i       (s_axis_tdata_i[31:16]),
    .offset_x_i     (s_axis_tdata_i[47:32]),
    .offset_y_i     (s_axis_tdata_i[63:48]),
    .center_valid_i (s_axis_tuser_i),
    .center_x_i     (s_axis_tdata_i[95:64]),
    .center_y_i     (s_axis_tdata_i[127:96]),
    .center_z_i     (s_axis_tdata_i[159:128]),
    .status_o       (status),
    .quat_x_o       (quat_x),
    .quat_y_o       (quat_y),
    .quat_z_o       (quat_z),
    .quat_w_o       (quat_w),
    .shift_x_o      (shift_x),
    .shift_y_o      (shift_y),
    .shift_z_o      (shift_z)
  );

  assign m_axis_tdata_o = {shift_z, shift_y, shift_x, quat_w, quat_z, quat_y, quat_x};

  // An accepted word starts a run, so the input side closes next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input still ready right after a word was accepted");

  // A fresh result only appears after a run, never out of idle
  a_result_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without a finished run");

  // The scalar part of the quaternion is never negative and at most one
  a_quat_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[63:48]) >= 0 &&
                         $signed(m_axis_tdata_o[63:48]) <= 16384))
    else $error("quaternion scalar out of range");

endmodule

// ----- hw/rtl/tbdr_isqrt.sv -----
// Bit-serial integer square root, two operand bits per cycle.
// Depends on tbdr_pkg for the operand and root widths.
`timescale 1ns / 1ps

module tbdr_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tbdr_pkg::SqOpW-1:0]  op_i,
  output logic                        busy_o,
  output logic [tbdr_pkg::RootW-1:0]  root_o
);
  import tbdr_pkg::*;

  localparam int unsigned CntW = $clog2(RootW + 1);

  logic [SqOpW-1:0] op_q;
  logic [RootW+2:0] rem_q, rem_sh, rem_sub;
  logic [RootW-1:0] root_q;
  logic [CntW-1:0]  cnt_q;
  logic [RootW+1:0] trial;
  logic             take;

  // One restoring step: bring down two bits, try subtracting 4r+1
  always_comb begin
    rem_sh  = {rem_q[RootW:0], op_q[SqOpW-1 -: 2]};
    trial   = {root_q, 2'b01};
    take    = rem_sh >= {1'b0, trial};
    rem_sub = rem_sh - {1'b0, trial};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(RootW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= op_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      op_q   <= {op_q[SqOpW-3:0], 2'b00};
      rem_q  <= take ? rem_sub : rem_sh;
      root_q <= {root_q[RootW-2:0], take};
    end
  end

  assign busy_o = cnt_q != '0;
  assign root_o = root_q;

endmodule

// ----- hw/rtl/tbdr_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tbdr_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module tbdr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tbdr_pkg::DvdW-1:0]  dividend_i,
  input  logic [tbdr_pkg::DvsW-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [tbdr_pkg::DvdW-1:0]  quot_o
);
  import tbdr_pkg::*;

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] dvd_q, quo_q;
  logic [DvsW-1:0] dvs_q, rem_q;
  logic [DvsW:0]   rem_sh, rem_sub;
  logic [CntW-1:0] cnt_q;
  logic            take;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    rem_sh  = {rem_q, dvd_q[DvdW-1]};
    take    = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(DvdW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q <= take ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
      quo_q <= {quo_q[DvdW-2:0], take};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quo_q;

endmodule

// ----- hw/rtl/tbdr_datapath.sv -----
// Datapath: operand registers, shared multiply-accumulate, result registers.
// Depends on tbdr_pkg, tbdr_isqrt and tbdr_div.
`timescale 1ns / 1ps

module tbdr_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tbdr_pkg::tbdr_cmd_t        cmd_i,
  input  logic [15:0]                grab_x_i,
  input  logic [15:0]                grab_y_i,
  input  logic [15:0]                offset_x_i,
  input  logic [15:0]                offset_y_i,
  input  logic                       center_valid_i,
  input  logic [31:0]                center_x_i,
  input  logic [31:0]                center_y_i,
  input  logic [31:0]                center_z_i,
  output tbdr_pkg::tbdr_status_t     status_o,
  output logic [15:0]                quat_x_o,
  output logic [15:0]                quat_y_o,
  output logic [15:0]                quat_z_o,
  output logic [15:0]                quat_w_o,
  output logic [31:0]                shift_x_o,
  output logic [31:0]                shift_y_o,
  output logic [31:0]                shift_z_o
);
  import tbdr_pkg::*;

  // Operand and intermediate registers
  logic signed [16:0] p1x_q, p1y_q, p2x_q, p2y_q;
  logic signed [15:0] ox_q, oy_q;
  logic signed [31:0] c_q [3];
  logic [12:0]        z1_q, z2_q;
  logic               pt_q;
  logic signed [34:0] a_q [3];
  logic [34:0]        m_q [3];
  logic signed [65:0] acc_q;
  logic [31:0]        n_q;
  logic [33:0]        dd2_q;
  logic [14:0]        t_q;
  logic signed [15:0] q_q [4];
  logic [1:0]         qidx_q;
  logic signed [29:0] prd_q [9];
  logic [3:0]         pidx_q;
  logic [1:0]         rr_q, jj_q;
  logic signed [31:0] sh_q [3];
  logic [15:0]        qo_q [4];
  logic [31:0]        so_q [3];

  // Multiplier and accumulator
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod, acc_base, mac_res;
  logic               mac_clr, mac_sub;
  logic signed [16:0] px, py;
  logic signed [13:0] dz;
  logic [34:0]        m_sel, mx;
  logic signed [15:0] pa, pb;
  logic signed [31:0] ps [9];
  logic signed [31:0] m_ent, c_sel;
  logic signed [34:0] a_sel;
  logic signed [65:0] rnd;
  logic signed [31:0] sat;

  // Square root and divider units
  logic              sq_start, dv_start, sq_busy, dv_busy;
  logic [SqOpW-1:0]  sq_op;
  logic [RootW-1:0]  sq_root;
  logic [DvdW-1:0]   dv_dvd, dv_quo;
  logic [DvsW-1:0]   dv_dvs;

  tbdr_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .op_i    (sq_op),
    .busy_o  (sq_busy),
    .root_o  (sq_root)
  );

  tbdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dvd),
    .divisor_i  (dv_dvs),
    .busy_o     (dv_busy),
    .quot_o     (dv_quo)
  );

  // Selected point, lift difference, largest axis magnitude
  always_comb begin
    px  = pt_q ? p2x_q : p1x_q;
    py  = pt_q ? p2y_q : p1y_q;
    dz  = $signed({1'b0, z2_q}) - $signed({1'b0, z1_q});
    mx  = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
    case (qidx_q)
      2'd0:    begin m_sel = m_q[0]; a_sel = a_q[0]; end
      2'd1:    begin m_sel = m_q[1]; a_sel = a_q[1]; end
      default: begin m_sel = m_q[2]; a_sel = a_q[2]; end
    endcase
  end

  // Quaternion product pairs: xx yy zz xy xz yz xw yw zw
  always_comb begin
    case (pidx_q)
      4'd0:    begin pa = q_q[0]; pb = q_q[0]; end
      4'd1:    begin pa = q_q[1]; pb = q_q[1]; end
      4'd2:    begin pa = q_q[2]; pb = q_q[2]; end
      4'd3:    begin pa = q_q[0]; pb = q_q[1]; end
      4'd4:    begin pa = q_q[0]; pb = q_q[2]; end
      4'd5:    begin pa = q_q[1]; pb = q_q[2]; end
      4'd6:    begin pa = q_q[0]; pb = q_q[3]; end
      4'd7:    begin pa = q_q[1]; pb = q_q[3]; end
      4'd8:    begin pa = q_q[2]; pb = q_q[3]; end
      default: begin pa = '0; pb = '0; end
    endcase
  end

  // Matrix entry of c - R*c for row rr, column jj
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ps[i] = 32'(prd_q[i]);
    end
    case ({rr_q, jj_q})
      4'b00_00: m_ent = (ps[1] + ps[2]) <<< 1;
      4'b00_01: m_ent = (ps[8] - ps[3]) <<< 1;
      4'b00_10: m_ent = -((ps[4] + ps[7]) <<< 1);
      4'b01_00: m_ent = -((ps[3] + ps[8]) <<< 1);
      4'b01_01: m_ent = (ps[0] + ps[2]) <<< 1;
      4'b01_10: m_ent = (ps[6] - ps[5]) <<< 1;
      4'b10_00: m_ent = (ps[7] - ps[4]) <<< 1;
      4'b10_01: m_ent = -((ps[5] + ps[6]) <<< 1);
      4'b10_10: m_ent = (ps[0] + ps[1]) <<< 1;
      default:  m_ent = '0;
    endcase
    case (jj_q)
      2'd0:    c_sel = c_q[0];
      2'd1:    c_sel = c_q[1];
      default: c_sel = c_q[2];
    endcase
  end

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mac_clr = 1'b0;
    mac_sub = 1'b0;
    unique case (cmd_i.op)
      CMD_SQ_X: begin mul_a = 33'(px); mul_b = 33'(px); mac_clr = 1'b1; end
      CMD_SQ_Y: begin mul_a = 33'(py); mul_b = 33'(py); end
      CMD_A0A: begin
        mul_a = 33'(p1y_q); mul_b = $signed({20'd0, z2_q}); mac_clr = 1'b1;
      end
      CMD_A0B: begin
        mul_a = $signed({20'd0, z1_q}); mul_b = 33'(p2y_q); mac_sub = 1'b1;
      end
      CMD_A1A: begin
        mul_a = $signed({20'd0, z1_q}); mul_b = 33'(p2x_q); mac_clr = 1'b1;
      end
      CMD_A1B: begin
        mul_a = 33'(p1x_q); mul_b = $signed({20'd0, z2_q}); mac_sub = 1'b1;
      end
      CMD_A2A: begin mul_a = 33'(p1x_q); mul_b = 33'(p2y_q); mac_clr = 1'b1; end
      CMD_A2B: begin mul_a = 33'(p1y_q); mul_b = 33'(p2x_q); mac_sub = 1'b1; end
      CMD_MM0: begin
        mul_a = $signed({2'b00, m_q[0][30:0]}); mul_b = mul_a; mac_clr = 1'b1;
      end
      CMD_MM1: begin mul_a = $signed({2'b00, m_q[1][30:0]}); mul_b = mul_a; end
      CMD_MM2: begin mul_a = $signed({2'b00, m_q[2][30:0]}); mul_b = mul_a; end
      CMD_DD0: begin mul_a = 33'(ox_q); mul_b = 33'(ox_q); mac_clr = 1'b1; end
      CMD_DD1: begin mul_a = 33'(oy_q); mul_b = 33'(oy_q); end
      CMD_DD2: begin mul_a = 33'(dz); mul_b = 33'(dz); end
      CMD_QM: begin
        mul_a = $signed({2'b00, m_sel[30:0]}); mul_b = $signed({18'd0, t_q});
        mac_clr = 1'b1;
      end
      CMD_PRD: begin mul_a = 33'(pa); mul_b = 33'(pb); mac_clr = 1'b1; end
      CMD_SHF: begin mul_a = 33'(m_ent); mul_b = 33'(c_sel); mac_clr = jj_q == 2'd0; end
      default: ;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign acc_base = mac_clr ? '0 : acc_q;
  assign mac_res  = mac_sub ? acc_base - prod : acc_base + prod;

  // Round Q44 to Q16 with ties upward, then saturate
  always_comb begin
    rnd = (mac_res + 66'sd134217728) >>> 28;
    if (rnd > 66'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (rnd < -66'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = rnd[31:0];
    end
  end

  // Operands and starts of the iterative units
  always_comb begin
    sq_start = 1'b0;
    sq_op    = acc_q[SqOpW-1:0];
    dv_start = 1'b0;
    dv_dvd   = acc_q[DvdW-1:0] + {17'd0, n_q[31:1]};
    dv_dvs   = {1'b0, n_q};
    unique case (cmd_i.op)
      CMD_SQRT_IN: begin
        sq_start = 1'b1;
        sq_op    = 64'd16777216 - acc_q[SqOpW-1:0];
      end
      CMD_SQRT_D2, CMD_SQRT_N: sq_start = 1'b1;
      CMD_SQRT_T: begin
        sq_start = 1'b1;
        sq_op    = {28'd0, dd2_q, 2'b00};
      end
      CMD_SQRT_W: begin
        sq_start = 1'b1;
        sq_op    = 64'd268435456 - {28'd0, dd2_q, 2'b00};
      end
      CMD_DIV_Z: begin
        dv_start = 1'b1;
        dv_dvd   = 48'd8388608;
        dv_dvs   = {1'b0, sq_root};
      end
      CMD_DIV_Q: dv_start = 1'b1;
      default: ;
    endcase
  end

  // Stored rotation center
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q[0] <= '0;
      c_q[1] <= '0;
      c_q[2] <= '0;
    end else if (cmd_i.op == CMD_LOAD && center_valid_i) begin
      c_q[0] <= center_x_i;
      c_q[1] <= center_y_i;
      c_q[2] <= center_z_i;
    end
  end

  // Working registers, written per step
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      CMD_LOAD: begin
        p1x_q  <= 17'($signed(grab_x_i));
        p1y_q  <= 17'($signed(grab_y_i));
        p2x_q  <= 17'($signed(grab_x_i)) + 17'($signed(offset_x_i));
        p2y_q  <= 17'($signed(grab_y_i)) + 17'($signed(offset_y_i));
        ox_q   <= offset_x_i;
        oy_q   <= offset_y_i;
        pt_q   <= 1'b0;
        qidx_q <= '0;
        pidx_q <= '0;
        rr_q   <= '0;
        jj_q   <= '0;
        q_q[0] <= '0;
        q_q[1] <= '0;
        q_q[2] <= '0;
        q_q[3] <= 16'(OneQ14);
      end
      CMD_SQ_X, CMD_SQ_Y, CMD_A0A, CMD_A1A, CMD_A2A, CMD_MM0, CMD_MM1, CMD_MM2,
      CMD_DD0, CMD_DD1, CMD_QM: acc_q <= mac_res;
      CMD_Z_SQRT, CMD_Z_DIV: begin
        if (pt_q) begin
          z2_q <= (cmd_i.op == CMD_Z_SQRT) ? sq_root[12:0] : dv_quo[12:0];
        end else begin
          z1_q <= (cmd_i.op == CMD_Z_SQRT) ? sq_root[12:0] : dv_quo[12:0];
        end
        pt_q <= 1'b1;
      end
      CMD_A0B: a_q[0] <= mac_res[34:0];
      CMD_A1B: a_q[1] <= mac_res[34:0];
      CMD_A2B: a_q[2] <= mac_res[34:0];
      CMD_ABS: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i] <= a_q[i] < 0 ? 35'(-a_q[i]) : 35'(a_q[i]);
        end
      end
      CMD_NORM: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i] <= (mx[34:30] != '0) ? (m_q[i] >> 1) : (m_q[i] << 1);
        end
      end
      CMD_N_WR: n_q <= sq_root;
      CMD_DD2: begin
        acc_q <= mac_res;
        dd2_q <= mac_res[33:0];
      end
      CMD_TBIG: begin
        t_q    <= 15'(OneQ14);
        q_q[3] <= '0;
      end
      CMD_T_WR: t_q <= (sq_root > 32'(OneQ14)) ? 15'(OneQ14) : sq_root[14:0];
      CMD_W_WR: q_q[3] <= sq_root[15:0];
      CMD_Q_WR: begin
        case (qidx_q)
          2'd0:    q_q[0] <= a_sel < 0 ? -dv_quo[15:0] : dv_quo[15:0];
          2'd1:    q_q[1] <= a_sel < 0 ? -dv_quo[15:0] : dv_quo[15:0];
          default: q_q[2] <= a_sel < 0 ? -dv_quo[15:0] : dv_quo[15:0];
        endcase
        qidx_q <= qidx_q + 1'b1;
      end
      CMD_PRD: begin
        case (pidx_q)
          4'd0: prd_q[0] <= mac_res[29:0];
          4'd1: prd_q[1] <= mac_res[29:0];
          4'd2: prd_q[2] <= mac_res[29:0];
          4'd3: prd_q[3] <= mac_res[29:0];
          4'd4: prd_q[4] <= mac_res[29:0];
          4'd5: prd_q[5] <= mac_res[29:0];
          4'd6: prd_q[6] <= mac_res[29:0];
          4'd7: prd_q[7] <= mac_res[29:0];
          default: prd_q[8] <= mac_res[29:0];
        endcase
        pidx_q <= pidx_q + 1'b1;
      end
      CMD_SHF: begin
        acc_q <= mac_res;
        if (jj_q == 2'd2) begin
          case (rr_q)
            2'd0:    sh_q[0] <= sat;
            2'd1:    sh_q[1] <= sat;
            default: sh_q[2] <= sat;
          endcase
          jj_q <= '0;
          rr_q <= rr_q + 1'b1;
        end else begin
          jj_q <= jj_q + 1'b1;
        end
      end
      CMD_OUT: begin
        for (int i = 0; i < 4; i++) begin
          qo_q[i] <= q_q[i];
        end
        for (int i = 0; i < 3; i++) begin
          so_q[i] <= sh_q[i];
        end
      end
      default: ;
    endcase
  end

  // Status back to the controller
  always_comb begin
    status_o.zero_off  = (ox_q == '0) && (oy_q == '0);
    status_o.pt_second = pt_q;
    status_o.in_sphere = acc_q < 66'sd8388608;
    status_o.zero_axis = (a_q[0] == '0) && (a_q[1] == '0) && (a_q[2] == '0);
    status_o.norm_ok   = (mx[34:30] == '0) && mx[29];
    status_o.big       = dd2_q[33:26] != '0;
    status_o.sqrt_busy = sq_busy;
    status_o.div_busy  = dv_busy;
    status_o.q_last    = qidx_q == 2'd2;
    status_o.p_last    = pidx_q == 4'd8;
    status_o.s_last    = (rr_q == 2'd2) && (jj_q == 2'd2);
  end

  assign quat_x_o  = qo_q[0];
  assign quat_y_o  = qo_q[1];
  assign quat_z_o  = qo_q[2];
  assign quat_w_o  = qo_q[3];
  assign shift_x_o = so_q[0];
  assign shift_y_o = so_q[1];
  assign shift_z_o = so_q[2];

endmodule

// ----- hw/rtl/tbdr_ctrl.sv -----
// Controller: sequences the datapath steps and runs both stream handshakes.
// Depends on tbdr_pkg for the command and status types.
`timescale 1ns / 1ps

module tbdr_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  output logic                    s_tready_o,
  output logic                    m_tvalid_o,
  input  logic                    m_tready_i,
  input  tbdr_pkg::tbdr_status_t  status_i,
  output tbdr_pkg::tbdr_cmd_t     cmd_o
);
  import tbdr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_LIFT, ST_LSQW, ST_LDIVW,
    ST_A0A, ST_A0B, ST_A1A, ST_A1B, ST_A2A, ST_A2B, ST_AXCHK,
    ST_NORM, ST_MM1, ST_MM2, ST_SQN, ST_NW,
    ST_DD0, ST_DD1, ST_DD2, ST_TCHK, ST_TW, ST_WSQ, ST_WW,
    ST_QM, ST_QDIV, ST_QW, ST_PROD, ST_SHF, ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_e   op;

  // Next state and step to issue
  always_comb begin
    state_d     = state_q;
    op          = CMD_NONE;
    out_valid_d = out_valid_q && !m_tready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          op      = CMD_LOAD;
          state_d = ST_SQX;
        end
      end
      ST_SQX: begin
        if (status_i.zero_off) begin
          state_d = ST_PROD;
        end else begin
          op      = CMD_SQ_X;
          state_d = ST_SQY;
        end
      end
      ST_SQY: begin op = CMD_SQ_Y; state_d = ST_LIFT; end
      ST_LIFT: begin
        op      = status_i.in_sphere ? CMD_SQRT_IN : CMD_SQRT_D2;
        state_d = ST_LSQW;
      end
      ST_LSQW: begin
        if (!status_i.sqrt_busy) begin
          if (status_i.in_sphere) begin
            op      = CMD_Z_SQRT;
            state_d = status_i.pt_second ? ST_A0A : ST_SQX;
          end else begin
            op      = CMD_DIV_Z;
            state_d = ST_LDIVW;
          end
        end
      end
      ST_LDIVW: begin
        if (!status_i.div_busy) begin
          op      = CMD_Z_DIV;
          state_d = status_i.pt_second ? ST_A0A : ST_SQX;
        end
      end
      ST_A0A: begin op = CMD_A0A; state_d = ST_A0B; end
      ST_A0B: begin op = CMD_A0B; state_d = ST_A1A; end
      ST_A1A: begin op = CMD_A1A; state_d = ST_A1B; end
      ST_A1B: begin op = CMD_A1B; state_d = ST_A2A; end
      ST_A2A: begin op = CMD_A2A; state_d = ST_A2B; end
      ST_A2B: begin op = CMD_A2B; state_d = ST_AXCHK; end
      ST_AXCHK: begin
        if (status_i.zero_axis) begin
          state_d = ST_PROD;
        end else begin
          op      = CMD_ABS;
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (status_i.norm_ok) begin
          op      = CMD_MM0;
          state_d = ST_MM1;
        end else begin
          op = CMD_NORM;
        end
      end
      ST_MM1: begin op = CMD_MM1; state_d = ST_MM2; end
      ST_MM2: begin op = CMD_MM2; state_d = ST_SQN; end
      ST_SQN: begin op = CMD_SQRT_N; state_d = ST_NW; end
      ST_NW: begin
        if (!status_i.sqrt_busy) begin
          op      = CMD_N_WR;
          state_d = ST_DD0;
        end
      end
      ST_DD0: begin op = CMD_DD0; state_d = ST_DD1; end
      ST_DD1: begin op = CMD_DD1; state_d = ST_DD2; end
      ST_DD2: begin op = CMD_DD2; state_d = ST_TCHK; end
      ST_TCHK: begin
        if (status_i.big) begin
          op      = CMD_TBIG;
          state_d = ST_QM;
        end else begin
          op      = CMD_SQRT_T;
          state_d = ST_TW;
        end
      end
      ST_TW: begin
        if (!status_i.sqrt_busy) begin
          op      = CMD_T_WR;
          state_d = ST_WSQ;
        end
      end
      ST_WSQ: begin op = CMD_SQRT_W; state_d = ST_WW; end
      ST_WW: begin
        if (!status_i.sqrt_busy) begin
          op      = CMD_W_WR;
          state_d = ST_QM;
        end
      end
      ST_QM: begin op = CMD_QM; state_d = ST_QDIV; end
      ST_QDIV: begin op = CMD_DIV_Q; state_d = ST_QW; end
      ST_QW: begin
        if (!status_i.div_busy) begin
          op      = CMD_Q_WR;
          state_d = status_i.q_last ? ST_PROD : ST_QM;
        end
      end
      ST_PROD: begin
        op = CMD_PRD;
        if (status_i.p_last) state_d = ST_SHF;
      end
      ST_SHF: begin
        op = CMD_SHF;
        if (status_i.s_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        // Move the result into the output register once it is free
        if (!out_valid_q || m_tready_i) begin
          op          = CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o = state_q == ST_IDLE;
  assign m_tvalid_o = out_valid_q;
  assign cmd_o.op   = op;

endmodule

// ----- tb/sv/trackball_drag_rotation_test.sv -----
// Self-checking bench for trackball_drag_rotation: directed table then random drags.
// Depends on trackball_drag_rotation (and tbdr_pkg below it); words checked by predictor or table.
`timescale 1ns / 1ps

module trackball_drag_rotation_test;

  localparam int unsigned  NumRandom   = 1250;
  localparam longint       CycleLimit  = 4000000;
  localparam int unsigned  DrainCycles = 600;
  localparam int unsigned  HoldCycles  = 3000;
  localparam int unsigned  OneQ14      = 16384;

  // One drag update as it goes into the block
  typedef struct packed {
    logic signed [15:0] grab_x;
    logic signed [15:0] grab_y;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic               center_valid;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } drag_t;

  // One rotation word as it comes out
  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } rot_t;

  // Directed row: the rotation is typed in only where it is plain to see
  typedef struct {
    drag_t drag;
    bit    known;
    rot_t  rot;
  } drag_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  // grab_x, grab_y, offset_x, offset_y, center_x, center_y, center_z
  logic [159:0] s_axis_tdata_i;
  // center_valid
  logic         s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  // quat_x, quat_y, quat_z, quat_w, shift_x, shift_y, shift_z
  logic [159:0] m_axis_tdata_o;

  trackball_drag_rotation dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  rot_t               rotation_queue[$];
  logic signed [31:0] pivot[3];
  int unsigned        error_count;
  int unsigned        words_out;
  int unsigned        words_in;
  int unsigned        pivot_loads;
  int unsigned        still_drags;
  int unsigned        clamped_turns;
  longint             cycle_count;

  // Bit-serial integer square root
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Height of a Q12 point on the sphere / hyperbolic sheet
  function automatic longint lift_height(longint x, longint y);
    longint unsigned d2;
    d2 = longint'(x * x) + longint'(y * y);
    if (d2 < (64'd1 << 23)) return longint'(root64((64'd1 << 24) - d2));
    return longint'((64'd1 << 23) / root64(d2));
  endfunction

  // Q44 to Q16, ties up, saturated to 32 bits
  function automatic logic signed [31:0] round_shift(longint v);
    longint q;
    q = (v + (64'sd1 <<< 27)) >>> 28;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  // Rotation and translation for one drag; updates the pivot on a load
  function automatic rot_t drag_rotation(drag_t d);
    longint          p1x, p1y, p2x, p2y, z1, z2, dx, dy, dz, s;
    longint          c[3], a[3], q[4], mat[3][3];
    longint unsigned m[3], mx, n, dd2, t, w, v;
    rot_t            r;
    if (d.center_valid) begin
      pivot[0] = d.center_x;
      pivot[1] = d.center_y;
      pivot[2] = d.center_z;
    end
    for (int i = 0; i < 3; i++) c[i] = pivot[i];
    q = '{0, 0, 0, OneQ14};
    p1x = d.grab_x;
    p1y = d.grab_y;
    if (d.offset_x != 0 || d.offset_y != 0) begin
      p2x = p1x + longint'(d.offset_x);
      p2y = p1y + longint'(d.offset_y);
      z1 = lift_height(p1x, p1y);
      z2 = lift_height(p2x, p2y);
      a[0] = p1y * z2 - z1 * p2y;
      a[1] = z1 * p2x - p1x * z2;
      a[2] = p1x * p2y - p1y * p2x;
      if (a[0] != 0 || a[1] != 0 || a[2] != 0) begin
        dx = p2x - p1x;
        dy = p2y - p1y;
        dz = z2 - z1;
        for (int i = 0; i < 3; i++) m[i] = a[i] < 0 ? -a[i] : a[i];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        // normalize the axis magnitude into [2^29, 2^30)
        while (mx >= (64'd1 << 30)) begin
          mx >>= 1;
          for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
          mx <<= 1;
          for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        n = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        dd2 = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
        if (dd2 >= (64'd4 << 24)) begin
          t = OneQ14;
          w = 0;
        end else begin
          t = root64(dd2 << 2);
          if (t > OneQ14) t = OneQ14;
          w = root64((64'd1 << 28) - (dd2 << 2));
        end
        for (int i = 0; i < 3; i++) begin
          v = (m[i] * t + n / 2) / n;
          q[i] = a[i] < 0 ? -longint'(v) : longint'(v);
        end
        q[3] = longint'(w);
      end
    end
    // rows of (I - R) scaled by 2^28
    mat[0][0] = 2 * (q[1] * q[1] + q[2] * q[2]);
    mat[0][1] = -2 * (q[0] * q[1] - q[2] * q[3]);
    mat[0][2] = -2 * (q[0] * q[2] + q[1] * q[3]);
    mat[1][0] = -2 * (q[0] * q[1] + q[2] * q[3]);
    mat[1][1] = 2 * (q[0] * q[0] + q[2] * q[2]);
    mat[1][2] = -2 * (q[1] * q[2] - q[0] * q[3]);
    mat[2][0] = -2 * (q[0] * q[2] - q[1] * q[3]);
    mat[2][1] = -2 * (q[1] * q[2] + q[0] * q[3]);
    mat[2][2] = 2 * (q[0] * q[0] + q[1] * q[1]);
    r.quat_x = q[0][15:0];
    r.quat_y = q[1][15:0];
    r.quat_z = q[2][15:0];
    r.quat_w = q[3][15:0];
    s = mat[0][0] * c[0] + mat[0][1] * c[1] + mat[0][2] * c[2];
    r.shift_x = round_shift(s);
    s = mat[1][0] * c[0] + mat[1][1] * c[1] + mat[1][2] * c[2];
    r.shift_y = round_shift(s);
    s = mat[2][0] * c[0] + mat[2][1] * c[1] + mat[2][2] * c[2];
    r.shift_z = round_shift(s);
    return r;
  endfunction

  function automatic drag_t make_drag(int gx, int gy, int ox, int oy, bit cv,
                                      int cx, int cy, int cz);
    drag_t d;
    d.grab_x = gx[15:0];
    d.grab_y = gy[15:0];
    d.offset_x = ox[15:0];
    d.offset_y = oy[15:0];
    d.center_valid = cv;
    d.center_x = cx;
    d.center_y = cy;
    d.center_z = cz;
    return d;
  endfunction

  // Random drag: mostly small strokes near the sphere, some full-range noise
  function automatic drag_t random_drag();
    drag_t       d;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    d.grab_x = (kind < 6) ? 16'($signed($urandom_range(0, 12000)) - 6000) : 16'($urandom);
    d.grab_y = (kind < 6) ? 16'($signed($urandom_range(0, 12000)) - 6000) : 16'($urandom);
    if (kind == 9) begin
      d.offset_x = 0;
      d.offset_y = 0;
    end else if (kind < 7) begin
      d.offset_x = 16'($signed($urandom_range(0, 4000)) - 2000);
      d.offset_y = 16'($signed($urandom_range(0, 4000)) - 2000);
    end else begin
      d.offset_x = 16'($urandom);
      d.offset_y = 16'($urandom);
    end
    d.center_valid = ($urandom_range(0, 3) == 0);
    d.center_x = ($urandom_range(0, 4) == 0) ? 32'($urandom) : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    d.center_y = ($urandom_range(0, 4) == 0) ? 32'($urandom) : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    d.center_z = ($urandom_range(0, 4) == 0) ? 32'($urandom) : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    return d;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Reset and cycle watchdog
  initial begin
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("trackball_drag_rotation_test failed");
      $finish;
    end
  end

  // Output word checker
  always @(posedge clk_i) begin
    rot_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      got = '{m_axis_tdata_o[15:0], m_axis_tdata_o[31:16], m_axis_tdata_o[47:32],
              m_axis_tdata_o[63:48], m_axis_tdata_o[95:64], m_axis_tdata_o[127:96],
              m_axis_tdata_o[159:128]};
      words_out++;
      if (rotation_queue.size() == 0) begin
        $error("rotation word with nothing expected");
        error_count++;
      end else begin
        want = rotation_queue.pop_front();
        if (want.quat_w == 0) clamped_turns++;
        check_field("quat_x", want.quat_x, got.quat_x);
        check_field("quat_y", want.quat_y, got.quat_y);
        check_field("quat_z", want.quat_z, got.quat_z);
        check_field("quat_w", want.quat_w, got.quat_w);
        check_field("shift_x", want.shift_x, got.shift_x);
        check_field("shift_y", want.shift_y, got.shift_y);
        check_field("shift_z", want.shift_z, got.shift_z);
      end
    end
  end

  // Receiver: random stalls in phases, one long hold to back up the block
  initial begin
    bit held;
    held = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && words_out == 100) begin
        held = 1;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      case ((words_out / 150) % 3)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready_i <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Send one word and hold it until accepted; predict on acceptance
  task automatic send_drag(drag_t d, bit known, rot_t typed);
    rot_t pred;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= d.center_valid;
    s_axis_tdata_i  <= {d.center_z, d.center_y, d.center_x,
                        d.offset_y, d.offset_x, d.grab_y, d.grab_x};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pred = drag_rotation(d);
    rotation_queue.push_back(known ? typed : pred);
    words_in++;
    if (d.center_valid) pivot_loads++;
    if (d.offset_x == 0 && d.offset_y == 0) still_drags++;
  endtask

  // Sender: bursts with random gaps, some stretches back to back
  task automatic pace(int unsigned idx, ref int unsigned burst_left);
    if (((idx / 200) % 2) == 1) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    drag_row_t   rows[$];
    drag_row_t   row;
    rot_t        ident;
    int unsigned burst_left;
    int unsigned idx;

    s_axis_tvalid_i <= 1'b0;
    s_axis_tuser_i  <= 1'b0;
    s_axis_tdata_i  <= '0;
    error_count = 0;
    words_out = 0;
    words_in = 0;
    pivot_loads = 0;
    still_drags = 0;
    clamped_turns = 0;
    cycle_count = 0;
    burst_left = 0;
    pivot = '{0, 0, 0};
    ident = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 32'sd0, 32'sd0, 32'sd0};

    // zero offset gives the identity, with or without a new pivot
    rows.push_back('{make_drag(0, 0, 0, 0, 0, 0, 0, 0), 1, ident});
    rows.push_back('{make_drag(-32768, 32767, 0, 0, 1, 32'h7fffffff, 32'h80000000,
                               32'h7fffffff), 1, ident});
    rows.push_back('{make_drag(32767, -32768, 0, 0, 0, 0, 0, 0), 1, ident});
    // small strokes inside the sphere, pivot at the extremes
    rows.push_back('{make_drag(0, 0, 409, 0, 0, 0, 0, 0), 0, ident});
    rows.push_back('{make_drag(1000, -500, -300, 700, 1, 32'h80000000, 32'h80000000,
                               32'h80000000), 0, ident});
    rows.push_back('{make_drag(-2000, 1500, 1, 0, 0, 0, 0, 0), 0, ident});
    rows.push_back('{make_drag(100, 100, -1, -1, 0, 0, 0, 0), 0, ident});
    // hyperbolic sheet and large distance clamp
    rows.push_back('{make_drag(16384, 0, -32768, 0, 1, 32'h00010000, 32'hffff0000,
                               32'h00020000), 0, ident});
    rows.push_back('{make_drag(-32768, -32768, 32767, 32767, 0, 0, 0, 0), 0, ident});
    rows.push_back('{make_drag(32767, 32767, -32768, -32768, 0, 0, 0, 0), 0, ident});
    rows.push_back('{make_drag(-4096, 0, 32767, 0, 0, 0, 0, 0), 0, ident});
    // strokes along an axis, one of them near the seam between sphere and sheet
    rows.push_back('{make_drag(2896, 0, 2, 0, 1, 32'h12345678, 32'h0, 32'hedcba988), 0, ident});
    rows.push_back('{make_drag(16384, 0, 16383, 0, 0, 0, 0, 0), 0, ident});
    rows.push_back('{make_drag(0, 32767, 0, -32768, 1, 0, 0, 0), 0, ident});

    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (rows[i]) begin
      row = rows[i];
      send_drag(row.drag, row.known, row.rot);
    end

    for (idx = 0; idx < NumRandom; idx++) begin
      if (idx == NumRandom / 2) begin
        // let the block drain completely once
        s_axis_tvalid_i <= 1'b0;
        while (rotation_queue.size() != 0) @(posedge clk_i);
      end
      pace(idx, burst_left);
      send_drag(random_drag(), 0, ident);
    end
    s_axis_tvalid_i <= 1'b0;

    while (rotation_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d drags (%0d still, %0d pivot loads), %0d words checked,",
             words_in, still_drags, pivot_loads, words_out);
    $display("%0d of them clamped to a half turn, in %0d cycles.", clamped_turns, cycle_count);
    if (error_count == 0 && rotation_queue.size() == 0) begin
      $display("trackball_drag_rotation_test passed");
    end else begin
      $display("trackball_drag_rotation_test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tbdr_pkg.sv
hw/rtl/tbdr_isqrt.sv
hw/rtl/tbdr_div.sv
hw/rtl/tbdr_datapath.sv
hw/rtl/tbdr_ctrl.sv
hw/rtl/trackball_drag_rotation.sv
tb/sv/trackball_drag_rotation_test.sv
